// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the noise generator RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is active
`define PNH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define PNH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pnh_pkg.sv -----
// Shared constants, stage map and control struct for the 1-D gradient noise pipeline.
// No dependencies.
package pnh_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 48;
    localparam int SEED_W        = 64;
    localparam int OUT_W         = 18;
    localparam int OUT_FRAC      = 16;
    localparam int OUT_MAX       = 131071;
    localparam int OUT_MIN       = -131072;

    // Hash finalizer constants
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_B  = 64'h94d049bb133111eb;
    localparam int SH_A = 30;
    localparam int SH_B = 27;
    localparam int SH_C = 31;

    // Seed registers hold seed + golden (left point) and seed + golden + 1 (right point)
    localparam logic [63:0] SEED_G0 = GOLDEN;
    localparam logic [63:0] SEED_G1 = GOLDEN + 64'd1;

    // Pipeline stage map
    localparam int NUM_STAGES = 8;
    localparam int ST_IN      = 1;  // floor, fraction, hash keys
    localparam int ST_MIX1    = 2;  // first hash multiply, fade step 1
    localparam int ST_SUM1    = 3;  // first hash partial sum, fade step 2
    localparam int ST_MIX2    = 4;  // second hash multiply, fade step 3
    localparam int ST_SUM2    = 5;  // second hash partial sum, fade step 4
    localparam int ST_SEL     = 6;  // gradient select, difference
    localparam int ST_MAC     = 7;  // fade * (b - a) + a
    localparam int ST_OUT     = 8;  // scale, saturate, output register

    typedef struct packed {
        logic [NUM_STAGES:1] en;    // load enable of each stage register
    } pnh_ctl_t;

endpackage

// ----- rtl/pnh_hash.sv -----
// Four-stage splitmix64-style finalizer that yields one gradient sign bit.
// Depends on pnh_pkg (constants, stage map, control struct).
module pnh_hash (
    input  logic            clk,
    input  pnh_pkg::pnh_ctl_t ctl,
    input  logic [63:0]     x,
    output logic            sign
);
    import pnh_pkg::*;

    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] ll1_next;
    logic [31:0] lh1_next;
    logic [31:0] hl1_next;
    logic [63:0] ll2_next;
    logic [31:0] lh2_next;
    logic [31:0] hl2_next;

    logic [63:0] ll1_reg;
    logic [31:0] lh1_reg;
    logic [31:0] hl1_reg;
    logic [63:0] p_reg;
    logic [63:0] ll2_reg;
    logic [31:0] lh2_reg;
    logic [31:0] hl2_reg;
    logic [63:0] h_reg;

    // 64x64 low-half product split into 32x32 partials
    always_comb
    begin
        y        = x ^ (x >> SH_A);
        ll1_next = 64'(y[31:0]) * 64'(MIX_A[31:0]);
        lh1_next = y[31:0] * MIX_A[63:32];
        hl1_next = y[63:32] * MIX_A[31:0];
        z        = p_reg ^ (p_reg >> SH_B);
        ll2_next = 64'(z[31:0]) * 64'(MIX_B[31:0]);
        lh2_next = z[31:0] * MIX_B[63:32];
        hl2_next = z[63:32] * MIX_B[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_MIX1])
        begin
            ll1_reg <= ll1_next;
            lh1_reg <= lh1_next;
            hl1_reg <= hl1_next;
        end
        if (ctl.en[ST_SUM1])
        begin
            p_reg <= ll1_reg + {lh1_reg + hl1_reg, 32'b0};
        end
        if (ctl.en[ST_MIX2])
        begin
            ll2_reg <= ll2_next;
            lh2_reg <= lh2_next;
            hl2_reg <= hl2_next;
        end
        if (ctl.en[ST_SUM2])
        begin
            h_reg <= ll2_reg + {lh2_reg + hl2_reg, 32'b0};
        end
    end

    // Bit 0 of h ^ (h >> 31)
    assign sign = h_reg[0] ^ h_reg[SH_C];

endmodule

// ----- rtl/pnh_fade.sv -----
// Quintic fade 6f^5-15f^4+10f^3 in Horner form, one multiply per stage.
// Depends on pnh_pkg (stage map, control struct).
module pnh_fade #(
    parameter int FRAC_BITS = pnh_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  pnh_pkg::pnh_ctl_t        ctl,
    input  logic [FRAC_BITS-1:0]     f_in,
    output logic [FRAC_BITS-1:0]     f_out,
    output logic signed [FRAC_BITS+5:0] fade
);
    import pnh_pkg::*;

    localparam int TW    = FRAC_BITS + 6;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int STEPS = 4;
    localparam logic signed [TW-1:0] K15 = TW'(15 * ONE);
    localparam logic signed [TW-1:0] K10 = TW'(10 * ONE);

    logic [FRAC_BITS-1:0]   f_src  [STEPS];
    logic signed [TW-1:0]   t_src  [STEPS];
    logic signed [TW-1:0]   fx     [STEPS];
    logic signed [2*TW-1:0] prod   [STEPS];
    logic signed [TW-1:0]   t_next [STEPS];
    logic signed [TW-1:0]   f_six;

    logic [FRAC_BITS-1:0]   f_reg  [STEPS];
    logic signed [TW-1:0]   t_reg  [STEPS];

    // Each step: t <- (f * t) >> F, plus 10 on the first
    always_comb
    begin
        f_six    = signed'(TW'(f_in));
        f_src[0] = f_in;
        t_src[0] = (f_six <<< 2) + (f_six <<< 1) - K15;
        for (int i = 1; i < STEPS; i++)
        begin
            f_src[i] = f_reg[i-1];
            t_src[i] = t_reg[i-1];
        end
        for (int i = 0; i < STEPS; i++)
        begin
            fx[i]     = signed'(TW'(f_src[i]));
            prod[i]   = fx[i] * t_src[i];
            t_next[i] = TW'(prod[i] >>> FRAC_BITS);
        end
        t_next[0] = t_next[0] + K10;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            if (ctl.en[ST_MIX1 + i])
            begin
                f_reg[i] <= f_src[i];
                t_reg[i] <= t_next[i];
            end
        end
    end

    assign f_out = f_reg[STEPS-1];
    assign fade  = t_reg[STEPS-1];

endmodule

// ----- rtl/pnh_blend.sv -----
// Gradient select, fade blend, doubling, scaling to Q1.16 and saturation.
// Depends on pnh_pkg (output format, stage map, control struct).
module pnh_blend #(
    parameter int FRAC_BITS = pnh_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  pnh_pkg::pnh_ctl_t           ctl,
    input  logic                        sign0,
    input  logic                        sign1,
    input  logic [FRAC_BITS-1:0]        f,
    input  logic signed [FRAC_BITS+5:0] fade,
    output logic signed [pnh_pkg::OUT_W-1:0] noise_value
);
    import pnh_pkg::*;

    localparam int TW  = FRAC_BITS + 6;
    localparam int BW  = FRAC_BITS + 3;
    localparam int SW  = FRAC_BITS + 5;
    localparam int QW  = FRAC_BITS + 22;
    localparam int ONE = 1 << FRAC_BITS;
    localparam logic signed [BW-1:0] ONE_B = BW'(ONE);
    localparam logic signed [QW-1:0] QMAX  = QW'(OUT_MAX);
    localparam logic signed [QW-1:0] QMIN  = QW'(OUT_MIN);

    logic signed [BW-1:0]    fe;
    logic signed [BW-1:0]    a_next;
    logic signed [BW-1:0]    b_val;
    logic signed [BW-1:0]    d_next;
    logic signed [TW+BW-1:0] m;
    logic signed [SW-1:0]    s_next;
    logic signed [SW:0]      r;
    logic signed [QW-1:0]    r_ext;
    logic signed [QW-1:0]    q_scl;
    logic signed [OUT_W-1:0] q_next;

    logic signed [BW-1:0]    a_reg;
    logic signed [BW-1:0]    d_reg;
    logic signed [TW-1:0]    fade_reg;
    logic signed [SW-1:0]    s_reg;
    logic signed [OUT_W-1:0] q_reg;

    // a = g0*f, b = g1*(f-1), difference b-a
    always_comb
    begin
        fe     = signed'(BW'(f));
        a_next = sign0 ? fe : -fe;
        b_val  = sign1 ? (fe - ONE_B) : (ONE_B - fe);
        d_next = b_val - a_next;
    end

    // a + (fade * (b-a)) >> F
    always_comb
    begin
        m      = fade_reg * d_reg;
        s_next = SW'(m >>> FRAC_BITS) + SW'(a_reg);
    end

    // Double, move to 16 fraction bits
    assign r     = {s_reg, 1'b0};
    assign r_ext = QW'(r);

    if (FRAC_BITS >= OUT_FRAC)
    begin : g_down
        assign q_scl = r_ext >>> (FRAC_BITS - OUT_FRAC);
    end
    else
    begin : g_up
        assign q_scl = r_ext <<< (OUT_FRAC - FRAC_BITS);
    end

    // Saturate
    always_comb
    begin
        priority if (q_scl > QMAX)
            q_next = OUT_W'(QMAX);
        else if (q_scl < QMIN)
            q_next = OUT_W'(QMIN);
        else
            q_next = OUT_W'(q_scl);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_SEL])
        begin
            a_reg    <= a_next;
            d_reg    <= d_next;
            fade_reg <= fade;
        end
        if (ctl.en[ST_MAC])
        begin
            s_reg <= s_next;
        end
        if (ctl.en[ST_OUT])
        begin
            q_reg <= q_next;
        end
    end

    assign noise_value = q_reg;

endmodule

// ----- rtl/perlin_noise_1d_hashed_gradient.sv -----
// 1-D hashed gradient noise, Q31.16 coordinate in, saturated Q1.16 sample out.
// Throughput one item per cycle while out_stall is low.
// Eight register stages set by the two split 64-bit hash multiplies and the fade chain.
// Each stage holds its item under output stall while bubbles ahead of it still fill.
// Reset (rst_n low, async) empties the pipeline and sets the seed to 0.
// Depends on pnh_pkg, pnh_hash, pnh_fade, pnh_blend and assert_macros.svh.
`include "assert_macros.svh"

module perlin_noise_1d_hashed_gradient #(
    parameter int FRAC_BITS = pnh_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pnh_pkg::SEED_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [pnh_pkg::COORD_W-1:0] coordinate,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pnh_pkg::OUT_W-1:0]  noise_value
);
    import pnh_pkg::*;

    logic [63:0]             sg0_reg;
    logic [63:0]             sg1_reg;
    logic [NUM_STAGES:1]     valid_reg;
    logic [NUM_STAGES+1:1]   ready;
    pnh_ctl_t                ctl;

    logic signed [63:0]      coord_ext;
    logic [63:0]             left;
    logic [63:0]             x0_reg;
    logic [63:0]             x1_reg;
    logic [FRAC_BITS-1:0]    f1_reg;

    logic                    sign0;
    logic                    sign1;
    logic [FRAC_BITS-1:0]    f5;
    logic signed [FRAC_BITS+5:0] fade5;

    // Seed plus golden constant, precomputed for both lattice points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg0_reg <= SEED_G0;
            sg1_reg <= SEED_G1;
        end
        else if (cfg_wr_en)
        begin
            sg0_reg <= cfg_wr_data + GOLDEN;
            sg1_reg <= cfg_wr_data + GOLDEN + 64'd1;
        end
    end

    // A stage loads when empty or when the stage after it moves
    always_comb
    begin
        ready[NUM_STAGES+1] = !out_stall;
        for (int k = NUM_STAGES; k >= 1; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        ctl.en = ready[NUM_STAGES:1];
    end

    assign in_stall  = !ready[ST_IN];
    assign out_valid = valid_reg[ST_OUT];

    // Valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[ST_IN])
                valid_reg[ST_IN] <= in_valid;
            for (int k = ST_IN + 1; k <= NUM_STAGES; k++)
            begin
                if (ready[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Floor, fraction and hash keys
    assign coord_ext = 64'(coordinate);
    assign left      = coord_ext >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_IN])
        begin
            x0_reg <= left + sg0_reg;
            x1_reg <= left + sg1_reg;
            f1_reg <= coordinate[FRAC_BITS-1:0];
        end
    end

    pnh_hash u_hash_left (
        .clk  (clk),
        .ctl  (ctl),
        .x    (x0_reg),
        .sign (sign0)
    );

    pnh_hash u_hash_right (
        .clk  (clk),
        .ctl  (ctl),
        .x    (x1_reg),
        .sign (sign1)
    );

    pnh_fade #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fade (
        .clk   (clk),
        .ctl   (ctl),
        .f_in  (f1_reg),
        .f_out (f5),
        .fade  (fade5)
    );

    pnh_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk         (clk),
        .ctl         (ctl),
        .sign0       (sign0),
        .sign1       (sign1),
        .f           (f5),
        .fade        (fade5),
        .noise_value (noise_value)
    );

    // Checks
    `PNH_ASSERT(a_stall_keeps_item, 1'b1 |=> ((($past(valid_reg) & ~$past(ctl.en)) & ~valid_reg) == '0), "stalled stage dropped its item")
    `PNH_ASSERT(a_accept_lands, in_valid && !in_stall |=> valid_reg[ST_IN], "accepted item missing from first stage")
    `PNH_ASSERT(a_stall_only_full, in_stall |-> ((&valid_reg) && out_stall), "input stalled with a bubble in the pipeline")
    `PNH_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (valid_reg == '0), "pipeline not empty during reset")

endmodule

// ----- tb/sv/perlin_noise_1d_hashed_gradient_checker.sv -----
`timescale 1ns / 1ps
// Checker for the 1-D hashed gradient noise block: predicts each noise sample
// from the accepted coordinate and the shadowed seed, and compares in order.
// Depends on pnh_pkg for widths and hash constants.
module perlin_noise_1d_hashed_gradient_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pnh_pkg::SEED_W-1:0]         cfg_wr_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [pnh_pkg::COORD_W-1:0] coordinate,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [pnh_pkg::OUT_W-1:0]   noise_value,
    output int                                 fail_count,
    output int                                 pending
);

    localparam int     FRAC = pnh_pkg::FRAC_BITS_DEF;
    localparam longint ONE  = longint'(1) << FRAC;

    logic [pnh_pkg::SEED_W-1:0]       seed_shadow;
    logic signed [pnh_pkg::OUT_W-1:0] expected_noise[$];
    logic signed [pnh_pkg::OUT_W-1:0] want;

    // Gradient sign of one lattice point: true means +1
    function automatic bit lattice_grad_up(input logic [63:0] idx);
        logic [63:0] h;
        h = idx + seed_shadow + pnh_pkg::GOLDEN;
        h = (h ^ (h >> pnh_pkg::SH_A)) * pnh_pkg::MIX_A;
        h = (h ^ (h >> pnh_pkg::SH_B)) * pnh_pkg::MIX_B;
        h = h ^ (h >> pnh_pkg::SH_C);
        return h[0];
    endfunction

    // Noise sample for one coordinate; >>> on signed longint floors
    function automatic logic signed [pnh_pkg::OUT_W-1:0] predict_noise(
        input logic signed [pnh_pkg::COORD_W-1:0] c);
        longint pos, left, f, g0, g1, t, fade, a, b, r, q;
        pos  = c;
        left = pos >>> FRAC;
        f    = pos & (ONE - 1);
        g0   = lattice_grad_up(left) ? 1 : -1;
        g1   = lattice_grad_up(left + 1) ? 1 : -1;
        // quintic fade by Horner steps
        t    = 6 * f - 15 * ONE;
        t    = ((f * t) >>> FRAC) + 10 * ONE;
        t    = (f * t) >>> FRAC;
        t    = (f * t) >>> FRAC;
        fade = (f * t) >>> FRAC;
        a    = g0 * f;
        b    = g1 * (f - ONE);
        r    = 2 * (a + ((fade * (b - a)) >>> FRAC));
        if (FRAC >= pnh_pkg::OUT_FRAC)
            q = r >>> (FRAC - pnh_pkg::OUT_FRAC);
        else
            q = r * (longint'(1) << (pnh_pkg::OUT_FRAC - FRAC));
        if (q > pnh_pkg::OUT_MAX)
            q = pnh_pkg::OUT_MAX;
        if (q < pnh_pkg::OUT_MIN)
            q = pnh_pkg::OUT_MIN;
        return q[pnh_pkg::OUT_W-1:0];
    endfunction

    // Watch both channels and the seed register
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_shadow = '0;
            expected_noise.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_noise.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual noise_value %0d",
                             $time, noise_value);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_noise.pop_front();
                    if (noise_value !== want)
                    begin
                        $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                                 $time, want, noise_value);
                        fail_count = fail_count + 1;
                    end
                end
            end
            // An item taken on a seed write edge still sees the old seed
            if (in_valid && !in_stall)
                expected_noise.insert(expected_noise.size(), predict_noise(coordinate));
            if (cfg_wr_en)
                seed_shadow = cfg_wr_data;
            pending = expected_noise.size();
        end
    end

endmodule

// ----- tb/sv/perlin_noise_1d_hashed_gradient_tb.sv -----
`timescale 1ns / 1ps
// Top of the noise block testbench: clock, reset, seed writes, coordinate items
// and output stalls; the checker beside the block does all comparing.
// Depends on pnh_pkg, perlin_noise_1d_hashed_gradient and its checker.
module perlin_noise_1d_hashed_gradient_tb;

    localparam int NUM_PHASES   = 7;
    localparam int RAND_ITEMS   = 260;
    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 20;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [pnh_pkg::SEED_W-1:0]         cfg_wr_data;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [pnh_pkg::COORD_W-1:0] coordinate;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [pnh_pkg::OUT_W-1:0]   noise_value;

    int fails;
    int outstanding;
    bit calm;
    bit hold_req;

    perlin_noise_1d_hashed_gradient u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coordinate  (coordinate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

    perlin_noise_1d_hashed_gradient_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coordinate  (coordinate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .fail_count  (fails),
        .pending     (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 50);
    endfunction

    // Lattice and fraction extremes
    function automatic logic [pnh_pkg::COORD_W-1:0] directed_coord(input int k);
        case (k)
            0:       return 48'h0000_0000_0000;
            1:       return 48'h7FFF_FFFF_FFFF;
            2:       return 48'h8000_0000_0000;
            3:       return 48'hFFFF_FFFF_FFFF;
            4:       return 48'h0000_0000_0001;
            5:       return 48'h0000_0000_FFFF;
            6:       return 48'h0000_0001_0000;
            7:       return 48'h0000_0000_8000;
            8:       return 48'hFFFF_FFFF_8000;
            9:       return 48'h7FFF_FFFF_0000;
            10:      return 48'h8000_0000_FFFF;
            default: return 48'h0000_0003_4000;
        endcase
    endfunction

    // Random coordinate: full range, near zero, or extreme fraction / integer part
    function automatic logic [pnh_pkg::COORD_W-1:0] random_coord();
        logic [31:0] ip;
        logic [15:0] fr;
        int          sel;
        sel = $urandom_range(0, 9);
        ip  = $urandom;
        fr  = $urandom;
        if (sel == 4 || sel == 5)
            ip = $urandom_range(0, 8) - 4;
        else if (sel == 6)
            case ($urandom_range(0, 5))
                0:       fr = 16'h0000;
                1:       fr = 16'h0001;
                2:       fr = 16'h7FFF;
                3:       fr = 16'h8000;
                4:       fr = 16'hFFFE;
                default: fr = 16'hFFFF;
            endcase
        else if (sel == 7)
            case ($urandom_range(0, 4))
                0:       ip = 32'h7FFF_FFFF;
                1:       ip = 32'h8000_0000;
                2:       ip = 32'hFFFF_FFFF;
                3:       ip = 32'h7FFF_FFFE;
                default: ip = 32'h0000_0000;
            endcase
        return {ip, fr};
    endfunction

    // Offer one item after an optional gap; returns at the falling edge after acceptance
    task automatic offer_coordinate(input logic [pnh_pkg::COORD_W-1:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        coordinate <= c;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Stop offering and wait for every outstanding sample
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_seed(input logic [pnh_pkg::SEED_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Output stalls: random bursts, plus one long hold on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req  = 1'b0;
                out_stall <= 1'b0;
            end
            else if (calm || $urandom_range(0, 3) != 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                if ($urandom_range(0, 99) < 85)
                    repeat ($urandom_range(0, 2)) @(negedge clk);
                else
                    repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int ph;
        int k;
        logic [pnh_pkg::SEED_W-1:0] seed;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        coordinate  = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Seed per phase; phase 0 keeps the reset value
            case (ph)
                0:       seed = '0;
                1:       seed = 64'hFFFF_FFFF_FFFF_FFFF;
                2:       seed = 64'h0000_0000_0000_0000;
                3:       seed = 64'h8000_0000_0000_0000;
                4:       seed = -pnh_pkg::GOLDEN;
                default: seed = {$urandom, $urandom};
            endcase
            if (ph != 0)
                write_seed(seed);
            calm = (ph == 2);

            if (ph < 2)
                for (k = 0; k < 12; k++)
                    offer_coordinate(directed_coord(k));

            for (k = 0; k < RAND_ITEMS; k++)
            begin
                // Long receiver hold with back-to-back items to fill the pipeline
                if (ph == 3 && k == 40)
                begin
                    hold_req = 1'b1;
                    calm     = 1'b1;
                end
                if (ph == 3 && k == 100)
                    calm = 1'b0;
                offer_coordinate(random_coord());
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fails == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
